>>> hdl/rhd_pkg.sv
`timescale 1ns / 1ps

package rhd_pkg;

   // Default geometry of the profile
   localparam int NUM_CELLS    = 77;
   localparam int INNER_OFFSET = 100;

   // Field widths
   localparam int TEMP_W     = 32;
   localparam int GAIN_W     = 32;
   localparam int SURF_W     = 31;
   localparam int MODE_W     = 2;
   localparam int CELL_REQ_W = 7;
   localparam int CSR_IDX_W  = 2;

   // Shared multiplier: signed operands, full product
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;

   // Operation codes carried in the mode field
   localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
   localparam logic [MODE_W-1:0] MODE_STEP = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ = 2'd2;
   localparam logic [MODE_W-1:0] MODE_NOP  = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIFFUSION_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOUNDARY_GAIN    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORE_CONDUCTANCE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SURFACE_TEMP     = 2'd3;

   // Register reset values
   localparam logic [GAIN_W-1:0] DIFFUSION_GAIN_RST   = 32'd27089218;
   localparam logic [GAIN_W-1:0] BOUNDARY_GAIN_RST    = 32'd677230443;
   localparam logic [GAIN_W-1:0] CORE_CONDUCTANCE_RST = 32'd2147484;
   localparam logic [SURF_W-1:0] SURFACE_TEMP_RST     = 31'd73033318;

   // Operand pair handed to the shared multiplier
   typedef struct packed {
      logic signed [MUL_W-1:0] a;
      logic signed [MUL_W-1:0] b;
   } mul_op_type;

endpackage

>>> hdl/rhd_if.sv
`timescale 1ns / 1ps

// Request channel: one operation word
interface rhd_req_if import rhd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [MODE_W-1:0]        mode;
   logic [CELL_REQ_W-1:0]    cell_req;
   logic signed [TEMP_W-1:0] cell_value;
   logic signed [TEMP_W-1:0] heat_increment;

   modport source (output valid, output mode, output cell_req, output cell_value,
                   output heat_increment, input ready);
   modport sink   (input valid, input mode, input cell_req, input cell_value,
                   input heat_increment, output ready);
endinterface

// Response channel: one result word per request
interface rhd_rsp_if import rhd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [TEMP_W-1:0] temperature_out;
   logic signed [TEMP_W-1:0] flux_out;
   logic                     saturated;

   modport source (output valid, output temperature_out, output flux_out,
                   output saturated, input ready);
   modport sink   (input valid, input temperature_out, input flux_out,
                   input saturated, output ready);
endinterface

>>> hdl/rhd_mul.sv
`timescale 1ns / 1ps

// Shared signed multiplier with a registered product
module rhd_mul import rhd_pkg::*; (
   input  logic                     clock,
   input  mul_op_type               op,
   output logic signed [PROD_W-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(signed'(op.a)) * PROD_W'(signed'(op.b));
   end

endmodule

>>> hdl/radial_heat_diffusion_step.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake      Word
// req_chan  in         valid / ready  mode, cell_req, cell_value, heat_increment
// rsp_chan  out        valid / ready  temperature_out, flux_out, saturated
// csr_*     in         csr_we         csr_index, csr_wdata
//
// Load and no-op go from accept straight to the response state; a read first
// waits for the registered memory read (not when the index is out of range).
// In a step every inner cell passes four times through the one shared 34x34
// multiplier, and the cell memory has one read port feeding a three-cell window.
// req_chan.ready is high only while idle; a result waits in the output
// register and the next word is accepted behind it. Reset is synchronous.
module radial_heat_diffusion_step import rhd_pkg::*; #(
   parameter int NumCells    = NUM_CELLS,
   parameter int InnerOffset = INNER_OFFSET
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [GAIN_W-1:0]    csr_wdata,
   rhd_req_if.sink              req_chan,
   rhd_rsp_if.source            rsp_chan
);

   localparam int CW        = $clog2(NumCells);
   localparam int NW        = $clog2(NumCells + InnerOffset);
   localparam int SUM_W     = 40;
   localparam int STEN_W    = 35;
   localparam int GX_W      = 36;
   localparam int RCP_W     = 33;
   localparam int RCP_SHIFT = 33;

   localparam logic signed [SUM_W-1:0] TEMP_MAX =
      SUM_W'((64'sd1 <<< (TEMP_W - 1)) - 64'sd1);
   localparam logic signed [SUM_W-1:0] TEMP_MIN = -TEMP_MAX - SUM_W'(1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ_WAIT, ST_RESP,
      ST_FETCH0, ST_FETCH1, ST_FETCH2, ST_FETCH3,
      ST_CELL_A, ST_CELL_B, ST_CELL_C, ST_CELL_D,
      ST_GM_LO, ST_GM_HI, ST_GM_SUM
   } state_type;

   typedef enum logic [1:0] {PH_CORE, PH_INNER, PH_FLUX} phase_type;

   // Configuration registers
   logic [GAIN_W-1:0] diffusion_gain_ff;
   logic [GAIN_W-1:0] boundary_gain_ff;
   logic [GAIN_W-1:0] core_cond_ff;
   logic [SURF_W-1:0] surface_ff;

   // Control
   state_type         state_ff, state_in;
   phase_type         phase_ff, phase_in;
   logic [CW-1:0]     cell_ff, cell_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic signed [TEMP_W-1:0] flux_ff, flux_in;

   // Data path
   logic signed [TEMP_W-1:0] heat_ff, heat_in;
   logic signed [TEMP_W-1:0] left_ff, left_in;
   logic signed [TEMP_W-1:0] mid_ff, mid_in;
   logic signed [TEMP_W-1:0] right_ff, right_in;
   logic signed [TEMP_W-1:0] fresh0_ff, fresh0_in;
   logic signed [TEMP_W-1:0] fresh1_ff, fresh1_in;
   logic signed [TEMP_W-1:0] res_temp_ff, res_temp_in;
   logic                     sat_ff, sat_in;
   logic signed [STEN_W-1:0] base_ff, base_in;
   logic [RCP_W-1:0]         a_ff, a_in;
   logic                     neg_ff, neg_in;
   logic [RCP_W-1:0]         q0_ff, q0_in;
   logic signed [GX_W-1:0]   gx_ff, gx_in;
   logic [RCP_W-1:0]         part_ff, part_in;
   logic [RCP_W-1:0]         recip_ff;
   logic signed [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic signed [TEMP_W-1:0] rsp_flux_ff, rsp_flux_in;
   logic                     rsp_sat_ff, rsp_sat_in;

   // Cell memory
   logic signed [TEMP_W-1:0] cells_mem [NumCells];
   logic signed [TEMP_W-1:0] rd_data_ff;
   logic                     rd_en, wr_en;
   logic [CW-1:0]            rd_addr, wr_addr;
   logic signed [TEMP_W-1:0] wr_data;

   // Shared multiplier
   mul_op_type               mul_op;
   logic signed [PROD_W-1:0] mul_p;

   // Reciprocal table: floor(2^33 / (cell + InnerOffset)), cell 0 taking the divisor of cell 1
   logic [RCP_W-1:0] recip_tab [NumCells];

   // Combinational helpers
   logic                     req_fire, slot_free, req_in_range;
   logic [CW-1:0]            req_addr;
   logic                     cell2_ok, is_last;
   logic [NW-1:0]            n_w, half_w;
   logic signed [RCP_W-1:0]  diff_w;
   logic [RCP_W-1:0]         abs_w;
   logic [NW:0]              r_w;
   logic                     bump_w;
   logic [GAIN_W-1:0]        gain_sel;
   logic signed [SUM_W-1:0]  gm_w, sum_base, sum_add, sum_w;
   logic signed [TEMP_W-1:0] clip_w;
   logic                     clip_hit;

   for (genvar g = 0; g < NumCells; g++) begin : g_recip
      localparam longint unsigned Divisor = longint'(((g == 0) ? 1 : g) + InnerOffset);
      assign recip_tab[g] = RCP_W'((64'd1 << RCP_SHIFT) / Divisor);
   end

   rhd_mul u_mul (
      .clock   (clock),
      .op      (mul_op),
      .prod_ff (mul_p)
   );

   // Handshake and port drive
   assign req_chan.ready           = (state_ff == ST_IDLE);
   assign req_fire                 = req_chan.valid && req_chan.ready;
   assign slot_free                = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.temperature_out = rsp_temp_ff;
   assign rsp_chan.flux_out        = rsp_flux_ff;
   assign rsp_chan.saturated       = rsp_sat_ff;

   assign req_addr     = CW'(req_chan.cell_req);
   assign req_in_range = 32'(req_chan.cell_req) < NumCells;
   assign cell2_ok     = (32'(cell_ff) + 2) < NumCells;
   assign is_last      = 32'(cell_ff) == (NumCells - 1);
   assign n_w          = NW'(32'(cell_ff) + InnerOffset);
   assign half_w       = n_w >> 1;

   // Stencil difference and rounding magnitude
   assign diff_w = RCP_W'(right_ff) - RCP_W'(left_ff);
   assign abs_w  = diff_w[RCP_W-1] ? RCP_W'(-diff_w) : RCP_W'(diff_w);

   // Remainder check against the quotient estimate
   assign r_w    = (NW + 1)'(a_ff - mul_p[RCP_W-1:0]);
   assign bump_w = r_w >= (NW + 1)'(n_w);

   // Pick gain and sum terms for the current phase
   always_comb begin
      case (phase_ff)
         PH_CORE: begin
            gain_sel = boundary_gain_ff;
            sum_base = SUM_W'(left_ff);
            sum_add  = '0;
         end
         PH_INNER: begin
            gain_sel = diffusion_gain_ff;
            sum_base = SUM_W'(mid_ff);
            sum_add  = SUM_W'(heat_ff);
         end
         default: begin
            gain_sel = core_cond_ff;
            sum_base = '0;
            sum_add  = '0;
         end
      endcase
   end

   // Gain product plus base, then saturate
   assign gm_w     = signed'(mul_p[SUM_W-1:0]) + SUM_W'(part_ff);
   assign sum_w    = sum_base + gm_w + sum_add;
   assign clip_hit = (sum_w > TEMP_MAX) || (sum_w < TEMP_MIN);
   assign clip_w   = (sum_w > TEMP_MAX) ? TEMP_W'(TEMP_MAX) :
                     (sum_w < TEMP_MIN) ? TEMP_W'(TEMP_MIN) : TEMP_W'(sum_w);

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cell_in      = cell_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      flux_in      = flux_ff;
      heat_in      = heat_ff;
      left_in      = left_ff;
      mid_in       = mid_ff;
      right_in     = right_ff;
      fresh0_in    = fresh0_ff;
      fresh1_in    = fresh1_ff;
      res_temp_in  = res_temp_ff;
      sat_in       = sat_ff;
      base_in      = base_ff;
      a_in         = a_ff;
      neg_in       = neg_ff;
      q0_in        = q0_ff;
      gx_in        = gx_ff;
      part_in      = part_ff;
      rsp_temp_in  = rsp_temp_ff;
      rsp_flux_in  = rsp_flux_ff;
      rsp_sat_in   = rsp_sat_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      mul_op       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               heat_in     = req_chan.heat_increment;
               sat_in      = 1'b0;
               res_temp_in = '0;
               unique case (req_chan.mode)
                  MODE_LOAD: begin
                     if (req_in_range) begin
                        wr_en       = 1'b1;
                        wr_addr     = req_addr;
                        wr_data     = req_chan.cell_value;
                        res_temp_in = req_chan.cell_value;
                     end
                     state_in = ST_RESP;
                  end
                  MODE_READ: begin
                     if (req_in_range) begin
                        rd_en    = 1'b1;
                        rd_addr  = req_addr;
                        state_in = ST_READ_WAIT;
                     end else begin
                        state_in = ST_RESP;
                     end
                  end
                  MODE_STEP: state_in = ST_FETCH0;
                  MODE_NOP:  state_in = ST_RESP;
               endcase
            end
         end
         ST_READ_WAIT: begin
            res_temp_in = rd_data_ff;
            state_in    = ST_RESP;
         end
         ST_RESP: begin
            // Hold until the output register is free
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_temp_in  = res_temp_ff;
               rsp_flux_in  = flux_ff;
               rsp_sat_in   = sat_ff;
               state_in     = ST_IDLE;
            end
         end
         // Fill the window with cells 0, 1 and 2
         ST_FETCH0: begin
            rd_en    = 1'b1;
            rd_addr  = CW'(0);
            state_in = ST_FETCH1;
         end
         ST_FETCH1: begin
            left_in  = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = CW'(1);
            state_in = ST_FETCH2;
         end
         ST_FETCH2: begin
            mid_in   = rd_data_ff;
            rd_en    = 1'b1;
            rd_addr  = CW'(2);
            state_in = ST_FETCH3;
         end
         ST_FETCH3: begin
            right_in = rd_data_ff;
            gx_in    = GX_W'(flux_ff);
            phase_in = PH_CORE;
            cell_in  = CW'(1);
            state_in = ST_GM_LO;
         end
         // Stencil terms; prefetch the cell two ahead
         ST_CELL_A: begin
            base_in = STEN_W'(right_ff) + STEN_W'(left_ff)
                      - STEN_W'(mid_ff) - STEN_W'(mid_ff);
            a_in    = abs_w + RCP_W'(half_w);
            neg_in  = diff_w[RCP_W-1];
            if (cell2_ok) begin
               rd_en   = 1'b1;
               rd_addr = CW'(32'(cell_ff) + 2);
            end
            state_in = ST_CELL_B;
         end
         ST_CELL_B: begin
            mul_op.a = MUL_W'(a_ff);
            mul_op.b = MUL_W'(recip_ff);
            state_in = ST_CELL_C;
         end
         ST_CELL_C: begin
            q0_in    = mul_p[RCP_SHIFT +: RCP_W];
            mul_op.a = MUL_W'(mul_p[RCP_SHIFT +: RCP_W]);
            mul_op.b = MUL_W'(n_w);
            state_in = ST_CELL_D;
         end
         ST_CELL_D: begin
            // Correct the quotient, apply the sign and add to the stencil
            if (neg_ff) begin
               gx_in = GX_W'(base_ff) - GX_W'(q0_ff) - GX_W'(bump_w);
            end else begin
               gx_in = GX_W'(base_ff) + GX_W'(q0_ff) + GX_W'(bump_w);
            end
            state_in = ST_GM_LO;
         end
         // Gain product: low word, then high word
         ST_GM_LO: begin
            mul_op.a = MUL_W'(gain_sel);
            mul_op.b = MUL_W'(gx_ff[31:0]);
            state_in = ST_GM_HI;
         end
         ST_GM_HI: begin
            part_in  = RCP_W'(({1'b0, mul_p[63:0]} + (65'd1 << 31)) >> 32);
            mul_op.a = MUL_W'(gain_sel);
            mul_op.b = MUL_W'(signed'(gx_ff[GX_W-1:32]));
            state_in = ST_GM_SUM;
         end
         ST_GM_SUM: begin
            unique case (phase_ff)
               PH_CORE: begin
                  fresh0_in = clip_w;
                  sat_in    = sat_ff | clip_hit;
                  wr_en     = 1'b1;
                  wr_addr   = CW'(0);
                  wr_data   = clip_w;
                  phase_in  = PH_INNER;
                  state_in  = ST_CELL_A;
               end
               PH_INNER: begin
                  sat_in  = sat_ff | clip_hit;
                  wr_en   = 1'b1;
                  wr_addr = cell_ff;
                  wr_data = clip_w;
                  if (cell_ff == CW'(1)) begin
                     fresh1_in = clip_w;
                  end
                  // Advance the window
                  left_in  = mid_ff;
                  mid_in   = right_ff;
                  right_in = cell2_ok ? rd_data_ff : TEMP_W'(surface_ff);
                  if (is_last) begin
                     gx_in    = GX_W'(fresh1_ff) - GX_W'(fresh0_ff);
                     phase_in = PH_FLUX;
                     state_in = ST_GM_LO;
                  end else begin
                     cell_in  = cell_ff + CW'(1);
                     state_in = ST_CELL_A;
                  end
               end
               PH_FLUX: begin
                  flux_in     = clip_w;
                  res_temp_in = fresh0_ff;
                  state_in    = ST_RESP;
               end
               default: state_in = ST_RESP;
            endcase
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_CORE;
         cell_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         flux_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cell_ff      <= cell_in;
         rsp_valid_ff <= rsp_valid_in;
         flux_ff      <= flux_in;
      end
   end

   // Data path registers
   always_ff @(posedge clock) begin
      heat_ff     <= heat_in;
      left_ff     <= left_in;
      mid_ff      <= mid_in;
      right_ff    <= right_in;
      fresh0_ff   <= fresh0_in;
      fresh1_ff   <= fresh1_in;
      res_temp_ff <= res_temp_in;
      sat_ff      <= sat_in;
      base_ff     <= base_in;
      a_ff        <= a_in;
      neg_ff      <= neg_in;
      q0_ff       <= q0_in;
      gx_ff       <= gx_in;
      part_ff     <= part_in;
      recip_ff    <= recip_tab[cell_ff];
      rsp_temp_ff <= rsp_temp_in;
      rsp_flux_ff <= rsp_flux_in;
      rsp_sat_ff  <= rsp_sat_in;
   end

   // Cell memory: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         cells_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= cells_mem[rd_addr];
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         diffusion_gain_ff <= DIFFUSION_GAIN_RST;
         boundary_gain_ff  <= BOUNDARY_GAIN_RST;
         core_cond_ff      <= CORE_CONDUCTANCE_RST;
         surface_ff        <= SURFACE_TEMP_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_DIFFUSION_GAIN:   diffusion_gain_ff <= csr_wdata;
            CSR_BOUNDARY_GAIN:    boundary_gain_ff  <= csr_wdata;
            CSR_CORE_CONDUCTANCE: core_cond_ff      <= csr_wdata;
            CSR_SURFACE_TEMP:     surface_ff        <= csr_wdata[SURF_W-1:0];
         endcase
      end
   end

endmodule
